// File: design/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg: shared constants and table builders for the stereo auto-panner
// Holds the fixed field widths, the sample bias and the elaboration-time
// functions that build the left-channel gain table from a Q30 Taylor series.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned StepW   = 24;
  localparam logic [SampleW-1:0] SampleBias = 8'h80;

  localparam logic [63:0] Q30One   = 64'd1073741824;
  localparam logic [63:0] Q30TwoPi = 64'd6746518852;
  localparam logic [63:0] Q15Half  = 64'd16384;
  localparam logic [63:0] Q15One   = 64'd32768;

  // Divide a series term by the factorial step of term n (constant divisors).
  function automatic logic [63:0] taylor_div(logic [63:0] v, int unsigned n, logic want_sin);
    logic [63:0] r;
    r = v;
    case (n)
      1: r = want_sin ? v / 64'd6   : v / 64'd2;
      2: r = want_sin ? v / 64'd20  : v / 64'd12;
      3: r = want_sin ? v / 64'd42  : v / 64'd30;
      4: r = want_sin ? v / 64'd72  : v / 64'd56;
      5: r = want_sin ? v / 64'd110 : v / 64'd90;
      6: r = want_sin ? v / 64'd156 : v / 64'd132;
      7: r = want_sin ? v / 64'd210 : v / 64'd182;
      default: r = v;
    endcase
    return r;
  endfunction

  // Q30 series for x in [0, pi/2), rounded half up to Q15 and held to 0..32768.
  function automatic logic [31:0] series_q15(logic [63:0] x, logic want_sin);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    int unsigned n;
    x2   = (x * x) >> 30;
    term = want_sin ? x : Q30One;
    sum  = longint'(term);
    for (n = 1; n <= 7; n++) begin
      term = taylor_div((term * x2) >> 30, n, want_sin);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) + Q15Half) >> 15;
    if (v > Q15One) begin
      v = Q15One;
    end
    return v[31:0];
  endfunction

  // Q1.15 cosine of entry k of a table of 2^tbits entries, by quadrant symmetry.
  function automatic int cos_entry(int unsigned k, int unsigned tbits);
    int unsigned quarter;
    int unsigned q;
    int unsigned m;
    logic [63:0] x;
    int          r;
    quarter = (32'd1 << tbits) >> 2;
    q       = (k >> (tbits - 2)) & 32'd3;
    m       = k & (quarter - 1);
    x       = (64'(m) * Q30TwoPi) >> tbits;
    case (q)
      0:       r =  int'(series_q15(x, 1'b0));
      1:       r = -int'(series_q15(x, 1'b1));
      2:       r = -int'(series_q15(x, 1'b0));
      default: r =  int'(series_q15(x, 1'b1));
    endcase
    return r;
  endfunction

  // Left gain (1+cos)/2 in unsigned Q1.gbits, truncated.
  function automatic logic [31:0] gain_entry(int unsigned k, int unsigned tbits,
                                             int unsigned gbits);
    logic [63:0] u;
    u = 64'(32768 + cos_entry(k, tbits));
    return 32'((u << gbits) >> 16);
  endfunction

endpackage

// File: design/sap_gain_rom.sv
// ----------------------------------------------------------------------------
// sap_gain_rom: left-channel gain table
// Synchronous ROM, one read a cycle, read data registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module sap_gain_rom
  import sap_pkg::*;
#(
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned GAIN_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [TABLE_BITS-1:0] rd_addr_i,
  output logic [GAIN_BITS:0]    rd_data_o
);

  localparam int unsigned Depth = 2 ** TABLE_BITS;
  localparam int unsigned GainW = GAIN_BITS + 1;

  logic [GainW-1:0] rom_w [Depth];
  logic [GainW-1:0] rd_data_q;

  for (genvar i = 0; i < Depth; i++) begin : g_rom
    assign rom_w[i] = GainW'(gain_entry(i, TABLE_BITS, GAIN_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rom_w[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/sap_scale.sv
// ----------------------------------------------------------------------------
// sap_scale: one channel of the panner
// Scale the centred sample by an unsigned gain, truncate toward zero and
// add the bias back.
// ----------------------------------------------------------------------------
module sap_scale
  import sap_pkg::*;
#(
  parameter int unsigned GAIN_BITS = 16
) (
  input  logic [SampleW-1:0] sample_i,
  input  logic [GAIN_BITS:0] gain_i,
  output logic [SampleW-1:0] result_o
);

  localparam int unsigned ProdW = SampleW + GAIN_BITS + 1;

  logic               neg_w;
  logic [SampleW-1:0] mag_w;
  logic [ProdW-1:0]   prod_w;
  logic [SampleW-1:0] part_w;

  // below the bias the centred value is negative
  assign neg_w  = ~sample_i[SampleW-1];
  assign mag_w  = neg_w ? (SampleBias - sample_i) : (sample_i - SampleBias);
  assign prod_w = ProdW'(mag_w) * ProdW'(gain_i);
  assign part_w = prod_w[GAIN_BITS +: SampleW];

  assign result_o = neg_w ? (SampleBias - part_w) : (SampleBias + part_w);

endmodule

// File: design/stereo_auto_pan.sv
// ----------------------------------------------------------------------------
// stereo_auto_pan: cosine auto-panner, mono sample in, stereo pair out
// Pipeline: two register stages (gain ROM, output); stage 1 holds the sample
// and its gain, the output register the pair, which it holds while stalled.
// Throughput: one transaction per cycle; the gain ROM read port is used once
// per sample; the input backs up only with both stages full and the output stalled.
// Reset: asynchronous, active low; clears phase, phase step and valid flags.
// The gain table is constant and needs no clearing pass.
// ----------------------------------------------------------------------------
module stereo_auto_pan
  import sap_pkg::*;
#(
  parameter int unsigned PHASE_BITS     = 24,
  parameter int unsigned COS_TABLE_BITS = 10,
  parameter int unsigned GAIN_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [StepW-1:0]   phase_step_i,
  // sample input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] mono_sample_i,
  // stereo output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] left_sample_o,
  output logic [SampleW-1:0] right_sample_o
);

  localparam int unsigned GainW = GAIN_BITS + 1;
  localparam logic [GainW-1:0] GainOne = GainW'(1) << GAIN_BITS;

  // Configuration: the step register is always writable.
  logic [StepW-1:0]      step_q;
  logic [PHASE_BITS-1:0] step_ext;

  // Phase accumulator: angle of the next sample to be accepted.
  logic [PHASE_BITS-1:0] phase_q;

  // Stage 1: sample waiting alongside its gain ROM read.
  logic                  s1_valid_q;
  logic [SampleW-1:0]    s1_sample_q;
  logic [GainW-1:0]      gain_left;
  logic [GainW-1:0]      gain_right;

  // Output register.
  logic                  out_valid_q;
  logic [SampleW-1:0]    left_q;
  logic [SampleW-1:0]    right_q;
  logic [SampleW-1:0]    left_d;
  logic [SampleW-1:0]    right_d;

  logic                  out_free;
  logic                  s1_adv;
  logic                  in_fire;

  assign cfg_ready_o = 1'b1;
  // Keep only the low phase bits of the step (or zero-extend a narrow one).
  assign step_ext    = PHASE_BITS'(step_q);

  // The output slot frees when empty or when its transaction completes;
  // stage 1 moves on into it, and a new sample enters stage 1 as it empties.
  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_adv     = s1_valid_q & out_free;
  assign in_ready_o = ~s1_valid_q | out_free;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      step_q <= phase_step_i;
    end
  end

  // Read the gain for the current phase as the sample is taken; the ROM
  // output holds while stage 1 stalls because no new read is issued.
  sap_gain_rom #(
    .TABLE_BITS (COS_TABLE_BITS),
    .GAIN_BITS  (GAIN_BITS)
  ) u_gain_rom (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (phase_q[PHASE_BITS-1 -: COS_TABLE_BITS]),
    .rd_data_o (gain_left)
  );

  // The two gains always sum to exactly one.
  assign gain_right = GainOne - gain_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_q + step_ext;
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= mono_sample_i;
    end
  end

  sap_scale #(
    .GAIN_BITS (GAIN_BITS)
  ) u_scale_left (
    .sample_i (s1_sample_q),
    .gain_i   (gain_left),
    .result_o (left_d)
  );

  sap_scale #(
    .GAIN_BITS (GAIN_BITS)
  ) u_scale_right (
    .sample_i (s1_sample_q),
    .gain_i   (gain_right),
    .result_o (right_d)
  );

  // Output register: load on advance, drop valid once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

  // Input only backs up when both stages are full and the output is stalled.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full, stalled pipeline");

  // Each accepted sample advances the phase by exactly the step.
  a_phase_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (phase_q == $past(phase_q + step_ext)))
    else $error("phase did not advance by the step");

  // A result can only appear when stage 1 held a sample.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("output became valid with no sample in stage 1");

  // A stalled output holds its stereo pair.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(left_q) && $stable(right_q)))
    else $error("stalled output pair changed");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stereo auto-panner
// Drives mono samples and phase-step writes through valid/ready channels and
// checks every pair against its typed-in pair or a local cosine-gain predictor.
// Random idling and stalls on both sides, long output hold-off, result drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sap_pkg::*;

  localparam int unsigned PHASE_BITS     = 24;
  localparam int unsigned COS_TABLE_BITS = 10;
  localparam int unsigned GAIN_BITS      = 16;
  localparam int unsigned COS_ENTRIES    = 1 << COS_TABLE_BITS;
  localparam longint unsigned Q30_UNITY  = 64'd1073741824;
  localparam longint unsigned Q30_TURN   = 64'd6746518852;
  localparam int unsigned PIPE_LATENCY   = 2;
  localparam int unsigned LONG_HOLD_CYCLES = 48;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned ITEMS_PER_PHASE = 225;

  // Kinds of row in the directed table.
  typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
  } stereo_pair_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [StepW-1:0]  value;   // phase step, or sample in the low bits
    logic              typed;   // expected pair given in the row
    stereo_pair_t      want;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 28;

  // Phase stays at zero until the first step write, so left follows the input
  // and right rests at the bias. A half-turn step swaps the channels on every
  // other sample; a quarter turn hits the zero-cosine points, where the gains
  // are equal and small products truncate toward zero. Full-scale step wraps.
  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{ROW_SAMPLE, 24'd0,     1'b1, '{8'd0,   8'd128}},
    '{ROW_SAMPLE, 24'd255,   1'b1, '{8'd255, 8'd128}},
    '{ROW_SAMPLE, 24'd128,   1'b1, '{8'd128, 8'd128}},
    '{ROW_SAMPLE, 24'd1,     1'b1, '{8'd1,   8'd128}},
    '{ROW_SAMPLE, 24'd127,   1'b1, '{8'd127, 8'd128}},
    '{ROW_SAMPLE, 24'd129,   1'b1, '{8'd129, 8'd128}},
    '{ROW_CONFIG, 24'h800000, 1'b0, '{8'd0,  8'd0}},
    '{ROW_SAMPLE, 24'd0,     1'b1, '{8'd0,   8'd128}},
    '{ROW_SAMPLE, 24'd0,     1'b1, '{8'd128, 8'd0}},
    '{ROW_SAMPLE, 24'd255,   1'b1, '{8'd255, 8'd128}},
    '{ROW_SAMPLE, 24'd255,   1'b1, '{8'd128, 8'd255}},
    '{ROW_CONFIG, 24'h400000, 1'b0, '{8'd0,  8'd0}},
    '{ROW_SAMPLE, 24'd0,     1'b1, '{8'd0,   8'd128}},
    '{ROW_SAMPLE, 24'd0,     1'b1, '{8'd64,  8'd64}},
    '{ROW_SAMPLE, 24'd255,   1'b1, '{8'd128, 8'd255}},
    '{ROW_SAMPLE, 24'd255,   1'b1, '{8'd191, 8'd191}},
    '{ROW_SAMPLE, 24'd127,   1'b1, '{8'd127, 8'd128}},
    '{ROW_SAMPLE, 24'd127,   1'b1, '{8'd128, 8'd128}},
    '{ROW_SAMPLE, 24'd129,   1'b1, '{8'd128, 8'd129}},
    '{ROW_SAMPLE, 24'd129,   1'b1, '{8'd128, 8'd128}},
    '{ROW_CONFIG, 24'hFFFFFF, 1'b0, '{8'd0,  8'd0}},
    '{ROW_SAMPLE, 24'd0,     1'b0, '{8'd0,   8'd0}},
    '{ROW_SAMPLE, 24'd255,   1'b0, '{8'd0,   8'd0}},
    '{ROW_SAMPLE, 24'd0,     1'b0, '{8'd0,   8'd0}},
    '{ROW_SAMPLE, 24'd200,   1'b0, '{8'd0,   8'd0}},
    '{ROW_CONFIG, 24'h000001, 1'b0, '{8'd0,  8'd0}},
    '{ROW_SAMPLE, 24'd37,    1'b0, '{8'd0,   8'd0}},
    '{ROW_SAMPLE, 24'd222,   1'b0, '{8'd0,   8'd0}}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [StepW-1:0]   phase_step = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SampleW-1:0] mono_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SampleW-1:0] left_sample;
  logic [SampleW-1:0] right_sample;

  // Tag travelling with the sample payload: a typed-in expectation, if any.
  logic               typed_tag = 1'b0;
  stereo_pair_t       typed_pair = '0;

  // Predictor state and the store of pairs still owed by the block.
  int unsigned        left_gain [0:COS_ENTRIES-1];
  logic [StepW-1:0]   step_model = '0;
  logic [PHASE_BITS-1:0] pan_angle = '0;
  stereo_pair_t       owed_pairs [$];

  int unsigned        mismatch_count = 0;
  bit                 sender_idle = 1'b1;
  bit                 receiver_idle = 1'b1;
  bit                 long_hold_req = 1'b0;

  stereo_auto_pan #(
    .PHASE_BITS    (PHASE_BITS),
    .COS_TABLE_BITS(COS_TABLE_BITS),
    .GAIN_BITS     (GAIN_BITS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .phase_step_i  (phase_step),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mono_sample_i (mono_sample),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .left_sample_o (left_sample),
    .right_sample_o(right_sample)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Q30 Taylor series of cos (or sin when odd) on the first quadrant, each
  // term truncated, the sum rounded half up to Q15 and held to 0..1.0.
  function automatic int unsigned taylor_q15(longint unsigned x, bit odd);
    longint unsigned x_sq;
    longint unsigned term;
    longint unsigned div;
    longint unsigned rounded;
    longint          acc;
    x_sq = (x * x) >> 30;
    term = odd ? x : Q30_UNITY;
    acc  = longint'(term);
    for (int n = 1; n <= 7; n++) begin
      div  = odd ? 64'(2 * n) : 64'(2 * n - 1);
      term = ((term * x_sq) >> 30) / (div * (div + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (64'(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32768) begin
      rounded = 64'd32768;
    end
    return int'(rounded);
  endfunction

  // Q1.15 cosine of table slot k, folded from the first quadrant.
  function automatic int cosine_q15(int unsigned k);
    int unsigned quarter_len;
    int unsigned quad;
    longint unsigned x;
    quarter_len = COS_ENTRIES / 4;
    quad = k / quarter_len;
    x    = (64'(k % quarter_len) * Q30_TURN) / COS_ENTRIES;
    case (quad)
      0:       return  int'(taylor_q15(x, 1'b0));
      1:       return -int'(taylor_q15(x, 1'b1));
      2:       return -int'(taylor_q15(x, 1'b0));
      default: return  int'(taylor_q15(x, 1'b1));
    endcase
  endfunction

  // Scale the centred sample by a gain, truncating the magnitude, and re-bias.
  function automatic logic [SampleW-1:0] pan_channel(int centred, int unsigned gain);
    longint unsigned mag;
    longint unsigned prod;
    int              level;
    mag   = (centred < 0) ? 64'(-centred) : 64'(centred);
    prod  = (mag * gain) >> GAIN_BITS;
    level = (centred < 0) ? int'(SampleBias) - int'(prod) : int'(SampleBias) + int'(prod);
    return level[SampleW-1:0];
  endfunction

  // Pair for a sample at the current pan angle; advance the angle after it.
  function automatic stereo_pair_t predict_pan(logic [SampleW-1:0] s);
    stereo_pair_t pair;
    int unsigned  gl;
    int           centred;
    gl         = left_gain[pan_angle[PHASE_BITS-1 -: COS_TABLE_BITS]];
    centred    = int'(s) - int'(SampleBias);
    pair.left  = pan_channel(centred, gl);
    pair.right = pan_channel(centred, (1 << GAIN_BITS) - gl);
    pan_angle  = pan_angle + step_model[PHASE_BITS-1:0];
    return pair;
  endfunction

  initial begin
    for (int k = 0; k < COS_ENTRIES; k++) begin
      left_gain[k] = int'((64'(32768 + cosine_q15(k)) << GAIN_BITS) >> 16);
    end
  end

  // Print one line per mismatch and count it.
  task automatic note_mismatch(string field, logic [SampleW-1:0] got,
                               logic [SampleW-1:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // Monitor: every process here reads the values from before the edge, so the
  // order against the drivers does not matter. Pop first: a result can never
  // belong to a transaction accepted at the same edge.
  always @(posedge clk) begin
    stereo_pair_t want;
    stereo_pair_t guess;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_pairs.size() == 0) begin
          mismatch_count++;
          $display("%0t: stereo pair with none outstanding: %0d/%0d",
                   $realtime, left_sample, right_sample);
        end else begin
          want = owed_pairs.pop_front();
          if (left_sample !== want.left) begin
            note_mismatch("left_sample", left_sample, want.left);
          end
          if (right_sample !== want.right) begin
            note_mismatch("right_sample", right_sample, want.right);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        step_model = phase_step;
      end
      if (in_valid && in_ready) begin
        guess = predict_pan(mono_sample);
        owed_pairs.push_back(typed_tag ? typed_pair : guess);
      end
    end
  end

  // Output side: drop ready at random before each transaction when idling, and
  // hold off for a long stretch once when asked.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      stall = receiver_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one sample, after a random gap when idling; return at the edge that
  // takes the transaction, with valid left high for a back-to-back follow-up.
  task automatic push_sample(logic [SampleW-1:0] s, logic typed, stereo_pair_t want);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mono_sample <= s;
    typed_tag   <= typed;
    typed_pair  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every owed pair has come out, plus the pipe.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_pairs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write the phase step while the block is idle.
  task automatic write_phase_step(logic [StepW-1:0] step);
    drain_results();
    cfg_valid  <= 1'b1;
    phase_step <= step;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1:       return 8'(127 + $urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [StepW-1:0] pick_step(int unsigned ph);
    if (ph == 0) begin
      return 24'hFFFFFF;
    end
    case ($urandom_range(0, 4))
      0:       return 24'(1 << $urandom_range(0, StepW - 1));
      1:       return 24'($urandom_range(1, 4095));
      2:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // Stimulus: reset, the directed table, then phases of random samples.
  initial begin
    directed_row_t row;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CONFIG) begin
        write_phase_step(row.value);
      end else begin
        push_sample(row.value[SampleW-1:0], row.typed, row.want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_phase_step(pick_step(ph));
      // Alternate idling so that some phases run flat out.
      sender_idle   = (ph % 3 != 1) && (ph != 2);
      receiver_idle = (ph % 4 != 2) || (ph == 2);
      if (ph == 2) begin
        // Hold the output off while the sender keeps pushing, so the block
        // fills and back-pressures its input.
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        push_sample(pick_sample(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stereo_auto_pan test passed");
    end else begin
      $display("stereo_auto_pan test failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run ends well inside this.
  initial begin
    #2000000;
    $display("stereo_auto_pan test failed");
    $finish;
  end

endmodule
